// File: hdl/q2e_pkg.sv
`default_nettype none
package q2e_pkg;

  localparam int CORDIC_ITER_DEF = 16;
  localparam int ATAN_LEN        = 24;

  // Q28 products and their two-term sums.
  localparam int PROD_W = 35;
  // CORDIC vector width, with room for the gain and the pre-rotation.
  localparam int CORDIC_W = 38;
  // Angle accumulator in 1/32768 degree.
  localparam int ACC_W = 25;

  // Square root of a 57-bit radicand, one result bit per stage.
  localparam int RAD_W      = 57;
  localparam int SQRT_STEPS = 29;
  localparam int SQRT_RES_W = 58;
  localparam int ROOT_W     = 29;
  localparam int SIN_W      = 28;

  localparam int ROLL_LIMIT  = 23040;
  localparam int PITCH_LIMIT = 11520;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  angle_acc_t;

  localparam prod_t      ONE_Q28 = prod_t'(64'sd268435456);
  localparam angle_acc_t DEG90   = angle_acc_t'(32'sd2949120);

  // atan(2^-i) in 1/32768 degree, rounded to the nearest unit.
  function automatic angle_acc_t atan_entry(input int idx);
    angle_acc_t v;
    case (idx)
      0:  v = angle_acc_t'(32'sd1474560);
      1:  v = angle_acc_t'(32'sd870484);
      2:  v = angle_acc_t'(32'sd459940);
      3:  v = angle_acc_t'(32'sd233473);
      4:  v = angle_acc_t'(32'sd117189);
      5:  v = angle_acc_t'(32'sd58652);
      6:  v = angle_acc_t'(32'sd29333);
      7:  v = angle_acc_t'(32'sd14667);
      8:  v = angle_acc_t'(32'sd7334);
      9:  v = angle_acc_t'(32'sd3667);
      10: v = angle_acc_t'(32'sd1833);
      11: v = angle_acc_t'(32'sd917);
      12: v = angle_acc_t'(32'sd458);
      13: v = angle_acc_t'(32'sd229);
      14: v = angle_acc_t'(32'sd115);
      15: v = angle_acc_t'(32'sd57);
      16: v = angle_acc_t'(32'sd29);
      17: v = angle_acc_t'(32'sd14);
      18: v = angle_acc_t'(32'sd7);
      19: v = angle_acc_t'(32'sd4);
      20: v = angle_acc_t'(32'sd2);
      21: v = angle_acc_t'(32'sd1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hdl/q2e_if.sv
`default_nettype none
interface q2e_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_clamped;

  modport source(output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                 input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
               output ready);
endinterface
`default_nettype wire

// File: hdl/q2e_isqrt.sv
`default_nettype none
module q2e_isqrt (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [q2e_pkg::RAD_W-1:0]    rad,
  output logic      [q2e_pkg::ROOT_W-1:0]   root
);
  import q2e_pkg::*;

  typedef logic [SQRT_RES_W-1:0] sq_t;

  sq_t rem_s [0:SQRT_STEPS];
  sq_t res_s [0:SQRT_STEPS];

  assign rem_s[0] = SQRT_RES_W'(rad);
  assign res_s[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam sq_t BIT = sq_t'(1) << (2 * (SQRT_STEPS - 1 - k));
    sq_t trial;
    assign trial = res_s[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_s[k] >= trial) begin
          rem_s[k+1] <= rem_s[k] - trial;
          res_s[k+1] <= (res_s[k] >> 1) + BIT;
        end else begin
          rem_s[k+1] <= rem_s[k];
          res_s[k+1] <= res_s[k] >> 1;
        end
      end
    end
  end

  assign root = res_s[SQRT_STEPS][ROOT_W-1:0];

endmodule
`default_nettype wire

// File: hdl/q2e_cordic.sv
`default_nettype none
module q2e_cordic #(
  parameter int ITER = q2e_pkg::CORDIC_ITER_DEF
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire q2e_pkg::prod_t      y_in,
  input  wire q2e_pkg::prod_t      x_in,
  output q2e_pkg::angle_acc_t      angle
);
  import q2e_pkg::*;

  localparam int N = (ITER > ATAN_LEN) ? ATAN_LEN : ITER;

  typedef logic signed [CORDIC_W-1:0] cw_t;

  cw_t        xs   [0:N];
  cw_t        ys   [0:N];
  angle_acc_t zs   [0:N];
  logic       zero [0:N];

  // A vector in the left half plane is first turned by a quarter circle.
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          xs[0] <= cw_t'(y_in);
          ys[0] <= -cw_t'(x_in);
          zs[0] <= DEG90;
        end else begin
          xs[0] <= -cw_t'(y_in);
          ys[0] <= cw_t'(x_in);
          zs[0] <= -DEG90;
        end
      end else begin
        xs[0] <= cw_t'(x_in);
        ys[0] <= cw_t'(y_in);
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam angle_acc_t ANG = atan_entry(i);
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ANG;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ANG;
        end
      end
    end
  end

  assign angle = zero[N] ? '0 : zs[N];

endmodule
`default_nettype wire

// File: hdl/quaternion_to_euler_angles_top.sv
// Stages: products, sine/cosine terms, pitch-sine square, radicand, square root, CORDIC, output.
// Throughput: one quaternion per cycle; the 29-stage square root and one stage per CORDIC step
// set the depth, and every stage takes a new item each cycle.
// While the result is not taken, the whole pipeline holds.
// Reset (synchronous, active high) clears the valid bits only.
`default_nettype none
module quaternion_to_euler_angles_top #(
  parameter int CORDIC_ITERATIONS = q2e_pkg::CORDIC_ITER_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  q2e_quat_if.sink       quat,
  q2e_euler_if.source    euler
);
  import q2e_pkg::*;

  localparam int N   = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
  localparam int LAT = 4 + SQRT_STEPS + N + 2;

  typedef struct packed {
    prod_t sr;
    prod_t cr;
    prod_t sy;
    prod_t cy;
    prod_t sp;
    logic  clamp;
    logic  neg;
  } side_t;

  typedef struct packed {
    logic clamp;
    logic neg;
  } pflag_t;

  logic en;
  logic vld [1:LAT];

  assign en         = !euler.valid || euler.ready;
  assign quat.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= quat.valid;
      for (int k = 2; k <= LAT; k++) vld[k] <= vld[k-1];
    end
  end

  assign euler.valid = vld[LAT];

  // Stage 1: the nine products, exact in Q28.
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= 32'(quat.quat_w * quat.quat_x);
      p_yz <= 32'(quat.quat_y * quat.quat_z);
      p_xx <= 32'(quat.quat_x * quat.quat_x);
      p_yy <= 32'(quat.quat_y * quat.quat_y);
      p_wz <= 32'(quat.quat_w * quat.quat_z);
      p_xy <= 32'(quat.quat_x * quat.quat_y);
      p_zz <= 32'(quat.quat_z * quat.quat_z);
      p_wy <= 32'(quat.quat_w * quat.quat_y);
      p_zx <= 32'(quat.quat_z * quat.quat_x);
    end
  end

  // Stage 2: sine and cosine terms.
  prod_t s2_sr, s2_cr, s2_sy, s2_cy, s2_sp;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sr <= (prod_t'(p_wx) + prod_t'(p_yz)) <<< 1;
      s2_cr <= ONE_Q28 - ((prod_t'(p_xx) + prod_t'(p_yy)) <<< 1);
      s2_sy <= (prod_t'(p_wz) + prod_t'(p_xy)) <<< 1;
      s2_cy <= ONE_Q28 - ((prod_t'(p_yy) + prod_t'(p_zz)) <<< 1);
      s2_sp <= (prod_t'(p_wy) - prod_t'(p_zx)) <<< 1;
    end
  end

  // Stage 3: square of the pitch sine. Its value only matters when not clamped,
  // and then it fits in SIN_W bits.
  prod_t                  sp_mag;
  logic [SIN_W-1:0]       sq;
  logic [2*SIN_W-1:0]     s3_sqsq;
  side_t                  s3_side;
  side_t                  s4_side;
  logic [RAD_W-1:0]       s4_rad;

  assign sp_mag = (s2_sp < 0) ? -s2_sp : s2_sp;
  assign sq     = sp_mag[SIN_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sqsq       <= sq * sq;
      s3_side.sr    <= s2_sr;
      s3_side.cr    <= s2_cr;
      s3_side.sy    <= s2_sy;
      s3_side.cy    <= s2_cy;
      s3_side.sp    <= s2_sp;
      s3_side.clamp <= (s2_sp >= ONE_Q28) || (s2_sp <= -ONE_Q28);
      s3_side.neg   <= s2_sp[PROD_W-1];
    end
  end

  // Stage 4: radicand 1 - s^2 in Q56.
  always_ff @(posedge clk) begin
    if (en) begin
      s4_rad  <= (RAD_W'(1) << (2 * SIN_W)) - RAD_W'(s3_sqsq);
      s4_side <= s3_side;
    end
  end

  logic [ROOT_W-1:0] cos_p;

  q2e_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s4_rad),
    .root (cos_p)
  );

  side_t dly [0:SQRT_STEPS];
  assign dly[0] = s4_side;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= SQRT_STEPS; k++) dly[k] <= dly[k-1];
    end
  end

  angle_acc_t roll_acc, pitch_acc, yaw_acc;

  q2e_cordic #(.ITER(N)) u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (dly[SQRT_STEPS].sr),
    .x_in  (dly[SQRT_STEPS].cr),
    .angle (roll_acc)
  );

  q2e_cordic #(.ITER(N)) u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (dly[SQRT_STEPS].sp),
    .x_in  (prod_t'(cos_p)),
    .angle (pitch_acc)
  );

  q2e_cordic #(.ITER(N)) u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (dly[SQRT_STEPS].sy),
    .x_in  (dly[SQRT_STEPS].cy),
    .angle (yaw_acc)
  );

  pflag_t pf [0:N+1];
  assign pf[0] = '{clamp: dly[SQRT_STEPS].clamp, neg: dly[SQRT_STEPS].neg};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= N + 1; k++) pf[k] <= pf[k-1];
    end
  end

  // Round to 1/128 degree with halves away from zero, then limit the magnitude.
  function automatic logic signed [15:0] round_limit(input angle_acc_t acc,
                                                     input logic [15:0] limit);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] sum;
    logic [15:0]      r;
    mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    sum = mag + ACC_W'(128);
    r   = 16'(sum[ACC_W-1:8]);
    if (r > limit) r = limit;
    return acc[ACC_W-1] ? -$signed(r) : $signed(r);
  endfunction

  logic signed [15:0] pitch_round;
  assign pitch_round = round_limit(pitch_acc, 16'(PITCH_LIMIT));

  always_ff @(posedge clk) begin
    if (en) begin
      euler.roll_angle    <= round_limit(roll_acc, 16'(ROLL_LIMIT));
      euler.yaw_angle     <= round_limit(yaw_acc, 16'(ROLL_LIMIT));
      euler.pitch_clamped <= pf[N+1].clamp;
      if (pf[N+1].clamp) begin
        euler.pitch_angle <= pf[N+1].neg ? -15'(PITCH_LIMIT) : 15'(PITCH_LIMIT);
      end else begin
        euler.pitch_angle <= pitch_round[14:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/q2e_checker.sv
`default_nettype none
module q2e_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] roll,
  input wire logic signed [14:0] pitch,
  input wire logic signed [15:0] yaw,
  input wire logic               clamped
);
  import q2e_pkg::*;

  // A result that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(roll) && $stable(pitch) && $stable(yaw) && $stable(clamped))
    else $error("result changed while stalled");

  // A stalled result stops input transfers; an empty output never does.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped |-> (pitch == 15'(PITCH_LIMIT)) || (pitch == -15'(PITCH_LIMIT)))
    else $error("clamped pitch is not a right angle");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> roll >= -ROLL_LIMIT && roll <= ROLL_LIMIT &&
                  yaw >= -ROLL_LIMIT && yaw <= ROLL_LIMIT &&
                  pitch >= -PITCH_LIMIT && pitch <= PITCH_LIMIT)
    else $error("angle out of range");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quaternion_to_euler_angles_top q2e_checker u_q2e_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (quat.ready),
  .out_valid (euler.valid),
  .out_ready (euler.ready),
  .roll      (euler.roll_angle),
  .pitch     (euler.pitch_angle),
  .yaw       (euler.yaw_angle),
  .clamped   (euler.pitch_clamped)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import q2e_pkg::*;

  localparam int NUM_RANDOM  = 800;
  localparam int WATCHDOG    = 20000;
  localparam int LATENCY     = 35 + CORDIC_ITER_DEF;
  localparam int NUM_ITERS   = (CORDIC_ITER_DEF < 24) ? CORDIC_ITER_DEF : 24;
  localparam longint ONE_Q28_L = 64'sd268435456;
  localparam longint DEG90_L   = 64'sd2949120;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    bit                 typed;
    euler_t             want;
  } quat_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sender_quiet = 1'b0;
  logic sink_quiet = 1'b0;
  int   errors = 0;
  int   results_seen = 0;
  int   clamped_seen = 0;
  int   idle_cycles = 0;
  euler_t angles_due[$];

  q2e_quat_if  quat();
  q2e_euler_if euler();

  quaternion_to_euler_angles_top u_top (
    .clk(clk), .rst(rst), .quat(quat.sink), .euler(euler.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // Angle of (cx, sy) in 1/32768 degree.
  function automatic longint vector_angle(longint sy, longint cx);
    longint ang, t, dx, dy;
    ang = 0;
    if (cx == 0 && sy == 0) return 0;
    if (cx < 0) begin
      if (sy >= 0) begin
        t = cx; cx = sy; sy = -t; ang = DEG90_L;
      end else begin
        t = cx; cx = -sy; sy = t; ang = -DEG90_L;
      end
    end
    for (int i = 0; i < NUM_ITERS; i++) begin
      dx = shr_floor(sy, i);
      dy = shr_floor(cx, i);
      if (sy > 0) begin
        cx = cx + dx; sy = sy - dy; ang += longint'(atan_entry(i));
      end else begin
        cx = cx - dx; sy = sy + dy; ang -= longint'(atan_entry(i));
      end
    end
    return ang;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint round_angle(longint acc, longint lim);
    longint mag, r;
    mag = acc < 0 ? -acc : acc;
    r = (mag + 128) >>> 8;
    if (acc < 0) r = -r;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t quat_to_euler(logic signed [15:0] qw, logic signed [15:0] qx,
                                           logic signed [15:0] qy, logic signed [15:0] qz);
    longint w, x, y, z, sp, cp;
    longint unsigned sq;
    euler_t e;
    w = qw; x = qx; y = qy; z = qz;
    e.roll = 16'(round_angle(vector_angle(2 * (w * x + y * z),
                                          ONE_Q28_L - 2 * (x * x + y * y)), ROLL_LIMIT));
    e.yaw = 16'(round_angle(vector_angle(2 * (w * z + x * y),
                                         ONE_Q28_L - 2 * (y * y + z * z)), ROLL_LIMIT));
    sp = 2 * (w * y - z * x);
    e.clamped = 1'b0;
    if (sp >= ONE_Q28_L) begin
      e.pitch = 15'(PITCH_LIMIT); e.clamped = 1'b1;
    end else if (sp <= -ONE_Q28_L) begin
      e.pitch = 15'(-PITCH_LIMIT); e.clamped = 1'b1;
    end else begin
      sq = longint'(sp < 0 ? -sp : sp);
      cp = int_sqrt((64'd1 << 56) - sq * sq);
      e.pitch = 15'(round_angle(vector_angle(sp, cp), PITCH_LIMIT));
    end
    return e;
  endfunction

  function automatic quat_row_t row(int w, int x, int y, int z, bit typed = 0,
                                    int r = 0, int p = 0, int yw = 0, bit c = 0);
    quat_row_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    q.typed = typed;
    q.want = '{roll: 16'(r), pitch: 15'(p), yaw: 16'(yw), clamped: c};
    return q;
  endfunction

  function automatic logic signed [15:0] rand_component();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return 16'($urandom_range(0, 8)) - 16'sd4;
    return 16'($urandom_range(0, 32768)) - 16'sd16384;
  endfunction

  // Sender: one transfer per call, driven at the falling edge.
  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    quat.valid <= 1'b1;
    quat.quat_w <= w; quat.quat_x <= x; quat.quat_y <= y; quat.quat_z <= z;
    do @(posedge clk); while (!quat.ready);
    @(negedge clk);
    if (sender_quiet && $urandom_range(0, 99) < 25) begin
      quat.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
  endtask

  // The predictor runs on every accepted transfer.
  always @(posedge clk) begin
    if (!rst && quat.valid && quat.ready)
      angles_due.push_back(quat_to_euler(quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z));
  end

  always @(posedge clk) begin
    euler_t due;
    if (!rst && euler.valid && euler.ready) begin
      results_seen++;
      if (euler.pitch_clamped) clamped_seen++;
      if (angles_due.size() == 0) begin
        $error("result transfer with no quaternion outstanding");
        errors++;
      end else begin
        due = angles_due.pop_front();
        if (euler.roll_angle !== due.roll) begin
          $error("roll_angle: expected %0d, got %0d", due.roll, euler.roll_angle);
          errors++;
        end
        if (euler.pitch_angle !== due.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", due.pitch, euler.pitch_angle);
          errors++;
        end
        if (euler.yaw_angle !== due.yaw) begin
          $error("yaw_angle: expected %0d, got %0d", due.yaw, euler.yaw_angle);
          errors++;
        end
        if (euler.pitch_clamped !== due.clamped) begin
          $error("pitch_clamped: expected %0b, got %0b", due.clamped, euler.pitch_clamped);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    euler.ready <= !(sink_quiet && $urandom_range(0, 99) < 25);
  end

  always @(posedge clk) begin
    if ((quat.valid && quat.ready) || (euler.valid && euler.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG);
      $display("quaternion_to_euler_angles_top verification failed");
      $finish;
    end
  end

  initial begin
    quat_row_t rows[$];
    euler_t    got;
    quat.valid = 1'b0;
    quat.quat_w = '0; quat.quat_x = '0; quat.quat_y = '0; quat.quat_z = '0;
    euler.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Identity and the zero vector give all-zero angles.
    rows.push_back(row(16384, 0, 0, 0, 1, 0, 0, 0, 0));
    rows.push_back(row(0, 0, 0, 0, 1, 0, 0, 0, 0));
    // Pitch saturation in both directions; roll and yaw land on a half turn.
    rows.push_back(row(11585, 0, 11585, 0));
    rows.push_back(row(16384, 0, 16384, 0, 1, ROLL_LIMIT, PITCH_LIMIT, ROLL_LIMIT, 1));
    rows.push_back(row(16384, 0, -16384, 0, 1, ROLL_LIMIT, -PITCH_LIMIT, ROLL_LIMIT, 1));
    rows.push_back(row(0, 16384, 0, 16384));
    // Half turns about each axis exercise the negative real part.
    rows.push_back(row(0, 16384, 0, 0));
    rows.push_back(row(0, 0, 16384, 0));
    rows.push_back(row(0, 0, 0, 16384));
    rows.push_back(row(0, -16384, 0, 0));
    rows.push_back(row(0, 0, 0, -16384));
    rows.push_back(row(11585, 11585, 0, 0));
    rows.push_back(row(11585, -11585, 0, 0));
    rows.push_back(row(11585, 0, 0, -11585));
    rows.push_back(row(-16384, -16384, -16384, -16384));
    rows.push_back(row(16384, 16384, 16384, 16384));
    // Out-of-range patterns, a near-zero quaternion and two unit quaternions with equal-size parts.
    rows.push_back(row(-32768, -32768, -32768, -32768));
    rows.push_back(row(32767, 32767, 32767, 32767));
    rows.push_back(row(-32768, 32767, -1, 1));
    rows.push_back(row(1, 0, 0, 0));
    rows.push_back(row(8192, 8192, 8192, 8192));
    rows.push_back(row(8192, -8192, 8192, -8192));

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        got = quat_to_euler(rows[i].w, rows[i].x, rows[i].y, rows[i].z);
        if (got !== rows[i].want) begin
          $error("directed row %0d: predictor disagrees with typed angles", i);
          errors++;
        end
      end
      send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // A long unbroken stretch first, then random gaps on both sides and one full drain halfway.
      sender_quiet = (n >= 150);
      sink_quiet = (n >= 150);
      if (n == 400) begin
        quat.valid <= 1'b0;
        wait (angles_due.size() == 0);
        @(negedge clk);
      end
      send_quat(rand_component(), rand_component(), rand_component(), rand_component());
    end
    quat.valid <= 1'b0;

    wait (angles_due.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d quaternions (directed and random); %0d results checked, %0d clamped.",
             rows.size() + NUM_RANDOM, results_seen, clamped_seen);
    if (errors == 0 && angles_due.size() == 0)
      $display("quaternion_to_euler_angles_top verification clean");
    else
      $display("quaternion_to_euler_angles_top verification failed");
    $finish;
  end
endmodule
`default_nettype wire
